// ----- hdl/fptw_pkg.sv -----
`default_nettype none

package fptw_pkg;

   // table geometry
   localparam int FRAME_COUNT_DEF   = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int LEVELS            = 4;
   localparam int IDX_W             = 9;
   localparam int LVL_W             = 2;
   localparam int OFFSET_W          = 12;

   // field widths
   localparam int OPCODE_W    = 2;
   localparam int VADDR_W     = 48;
   localparam int ROOT_W      = 6;
   localparam int FRAME_OUT_W = 6;
   localparam int TAKEN_W     = 3;
   localparam int UNDO_CNT_W  = 3;
   localparam int FLAG_W      = 3;

   // word widths on the streams
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USED_W = 18;

   // bit position of the writable flag in the request word
   localparam int REQ_WRITABLE_BIT = VADDR_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CHECK = 2'd0,
      OP_UNMAP = 2'd1,
      OP_FILL  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_UNDO,
      S_DONE
   } state_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_START,
      DP_READ,
      DP_WALK,
      DP_HIT,
      DP_UNMAP,
      DP_FILL_OR,
      DP_FILL_ALLOC,
      DP_UNDO,
      DP_FAIL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic present;
      logic leaf;
      logic alloc_ok;
      logic undo_empty;
   } sts_type;

endpackage

`default_nettype wire

// ----- hdl/fptw_dp.sv -----
`default_nettype none

module fptw_dp #(
   parameter int FRAME_COUNT = fptw_pkg::FRAME_COUNT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [fptw_pkg::ROOT_W-1:0]     csr_data,
   input  wire logic [fptw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire fptw_pkg::cmd_type               cmd,
   output fptw_pkg::sts_type                    sts,
   output logic      [fptw_pkg::RSP_DATA_W-1:0] rsp_data
);
   import fptw_pkg::*;

   localparam int FW         = $clog2(FRAME_COUNT);
   localparam int AW         = FW + IDX_W;
   localparam int DEPTH      = FRAME_COUNT * ENTRIES_PER_TABLE;
   localparam int EW         = FW + FLAG_W;
   localparam int NW         = $clog2(FRAME_COUNT + 1);
   localparam int RMW        = (FW > ROOT_W) ? FW : ROOT_W;
   localparam int XW         = FW + FRAME_OUT_W;
   localparam int ROOT_STEPS = ((1 << ROOT_W) - 1) / FRAME_COUNT;

   // table store, one entry per slot: frame number above the access flags
   logic [EW-1:0] table_mem [DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] mem_addr;
   logic [EW-1:0] mem_wdata;

   // control and walk registers
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic [FW-1:0]         frame_ff, frame_in;
   logic [IDX_W-1:0]      idx_ff [LEVELS];
   logic [IDX_W-1:0]      idx_in [LEVELS];
   logic [FLAG_W-1:0]     acc_ff, acc_in;
   logic [NW-1:0]         nff_ff, nff_in;
   logic [NW-1:0]         saved_ff, saved_in;
   logic [UNDO_CNT_W-1:0] undo_cnt_ff, undo_cnt_in;
   logic [AW-1:0]         undo_addr_ff [LEVELS];
   logic [AW-1:0]         undo_addr_in [LEVELS];
   logic [EW-1:0]         undo_val_ff [LEVELS];
   logic [EW-1:0]         undo_val_in [LEVELS];

   // working result fields
   logic                   mapped_ff, mapped_in;
   logic                   freed_ff, freed_in;
   logic [FRAME_OUT_W-1:0] freed_frame_ff, freed_frame_in;
   logic [FRAME_OUT_W-1:0] data_frame_ff, data_frame_in;
   logic [TAKEN_W-1:0]     taken_ff, taken_in;
   logic                   oof_ff, oof_in;
   logic [RSP_DATA_W-1:0]  rsp_ff;

   logic [RMW-1:0]         root_mod;
   logic [IDX_W-1:0]       idx_sel;
   logic [AW-1:0]          cur_addr;
   logic [LVL_W-1:0]       undo_top;
   logic [FW-1:0]          ent_frame;
   logic [FW-1:0]          new_frame;
   logic [XW-1:0]          ent_frame_x;
   logic [XW-1:0]          new_frame_x;

   // root frame reduced into the store by ROOT_STEPS compare-subtract steps
   always_comb begin
      root_mod = RMW'(root_ff);
      for (int i = 0; i < ROOT_STEPS; i++) begin
         if (root_mod >= RMW'(FRAME_COUNT)) begin
            root_mod = root_mod - RMW'(FRAME_COUNT);
         end
      end
   end

   assign idx_sel     = idx_ff[lvl_ff];
   assign cur_addr    = {frame_ff, idx_sel};
   assign undo_top    = undo_cnt_ff[LVL_W-1:0] - LVL_W'(1);
   assign ent_frame   = rd_data_ff[EW-1:FLAG_W];
   assign new_frame   = nff_ff[FW-1:0];
   assign ent_frame_x = XW'(ent_frame);
   assign new_frame_x = XW'(new_frame);

   // status to the controller
   assign sts.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign sts.present    = rd_data_ff[0];
   assign sts.leaf       = (lvl_ff == LVL_W'(LEVELS - 1));
   assign sts.alloc_ok   = (nff_ff < NW'(FRAME_COUNT));
   assign sts.undo_empty = (undo_cnt_ff == '0);

   // next state of the datapath per command
   always_comb begin
      root_in        = root_ff;
      clr_in         = clr_ff;
      lvl_in         = lvl_ff;
      frame_in       = frame_ff;
      idx_in         = idx_ff;
      acc_in         = acc_ff;
      nff_in         = nff_ff;
      saved_in       = saved_ff;
      undo_cnt_in    = undo_cnt_ff;
      undo_addr_in   = undo_addr_ff;
      undo_val_in    = undo_val_ff;
      mapped_in      = mapped_ff;
      freed_in       = freed_ff;
      freed_frame_in = freed_frame_ff;
      data_frame_in  = data_frame_ff;
      taken_in       = taken_ff;
      oof_in         = oof_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = cur_addr;
      mem_wdata      = '0;

      if (csr_valid) begin
         root_in = csr_data;
      end

      case (cmd.op)
         DP_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + AW'(1);
         end
         DP_START: begin
            for (int l = 0; l < LEVELS; l++) begin
               idx_in[l] = req_tdata[OFFSET_W + IDX_W * (LEVELS - 1 - l) +: IDX_W];
            end
            frame_in       = root_mod[FW-1:0];
            lvl_in         = '0;
            acc_in         = {1'b1, req_tdata[REQ_WRITABLE_BIT], 1'b1};
            saved_in       = nff_ff;
            undo_cnt_in    = '0;
            mapped_in      = 1'b0;
            freed_in       = 1'b0;
            freed_frame_in = '0;
            data_frame_in  = '0;
            taken_in       = '0;
            oof_in         = 1'b0;
         end
         DP_READ: begin
            mem_re = 1'b1;
         end
         DP_WALK: begin
            frame_in = ent_frame;
            lvl_in   = lvl_ff + LVL_W'(1);
         end
         DP_HIT: begin
            mapped_in = 1'b1;
         end
         DP_UNMAP: begin
            mem_we         = 1'b1;
            freed_in       = 1'b1;
            freed_frame_in = ent_frame_x[FRAME_OUT_W-1:0];
         end
         DP_FILL_OR: begin
            mem_we      = 1'b1;
            mem_wdata   = rd_data_ff | EW'(acc_ff);
            undo_addr_in[undo_cnt_ff[LVL_W-1:0]] = cur_addr;
            undo_val_in[undo_cnt_ff[LVL_W-1:0]]  = rd_data_ff;
            undo_cnt_in = undo_cnt_ff + UNDO_CNT_W'(1);
            frame_in    = ent_frame;
            lvl_in      = lvl_ff + LVL_W'(1);
         end
         DP_FILL_ALLOC: begin
            mem_we      = 1'b1;
            mem_wdata   = {new_frame, acc_ff};
            undo_addr_in[undo_cnt_ff[LVL_W-1:0]] = cur_addr;
            undo_val_in[undo_cnt_ff[LVL_W-1:0]]  = rd_data_ff;
            undo_cnt_in = undo_cnt_ff + UNDO_CNT_W'(1);
            frame_in    = new_frame;
            nff_in      = nff_ff + NW'(1);
            taken_in    = taken_ff + TAKEN_W'(1);
            lvl_in      = lvl_ff + LVL_W'(1);
            if (sts.leaf) begin
               data_frame_in = new_frame_x[FRAME_OUT_W-1:0];
            end
         end
         DP_UNDO: begin
            mem_we      = 1'b1;
            mem_addr    = undo_addr_ff[undo_top];
            mem_wdata   = undo_val_ff[undo_top];
            undo_cnt_in = undo_cnt_ff - UNDO_CNT_W'(1);
         end
         DP_FAIL: begin
            oof_in        = 1'b1;
            taken_in      = '0;
            data_frame_in = '0;
            nff_in        = saved_ff;
         end
         default: begin
         end
      endcase
   end

   // table memory, single port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= table_mem[mem_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff     <= '0;
         clr_ff      <= '0;
         lvl_ff      <= '0;
         nff_ff      <= NW'(1);
         undo_cnt_ff <= '0;
      end else begin
         root_ff     <= root_in;
         clr_ff      <= clr_in;
         lvl_ff      <= lvl_in;
         nff_ff      <= nff_in;
         undo_cnt_ff <= undo_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      frame_ff       <= frame_in;
      idx_ff         <= idx_in;
      acc_ff         <= acc_in;
      saved_ff       <= saved_in;
      undo_addr_ff   <= undo_addr_in;
      undo_val_ff    <= undo_val_in;
      mapped_ff      <= mapped_in;
      freed_ff       <= freed_in;
      freed_frame_ff <= freed_frame_in;
      data_frame_ff  <= data_frame_in;
      taken_ff       <= taken_in;
      oof_ff         <= oof_in;
      if (cmd.load_rsp) begin
         rsp_ff <= {(RSP_DATA_W - RSP_USED_W)'(0), oof_ff, taken_ff, data_frame_ff,
                    freed_frame_ff, freed_ff, mapped_ff};
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ----- hdl/fptw_ctrl.sv -----
`default_nettype none

module fptw_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [fptw_pkg::OPCODE_W-1:0] req_opcode,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire fptw_pkg::sts_type             sts,
   output fptw_pkg::cmd_type                  cmd
);
   import fptw_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready   = 1'b0;
      cmd.op       = DP_NOP;
      cmd.load_rsp = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = DP_START;
               op_in  = op_type'(req_opcode);
               if (op_type'(req_opcode) == OP_NOP) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.op   = DP_READ;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (op_ff)
               OP_CHECK, OP_UNMAP: begin
                  if (!sts.present) begin
                     state_in = S_DONE;
                  end else if (sts.leaf) begin
                     cmd.op   = (op_ff == OP_CHECK) ? DP_HIT : DP_UNMAP;
                     state_in = S_DONE;
                  end else begin
                     cmd.op   = DP_WALK;
                     state_in = S_READ;
                  end
               end
               OP_FILL: begin
                  if (sts.present && !sts.leaf) begin
                     cmd.op   = DP_FILL_OR;
                     state_in = S_READ;
                  end else if (sts.alloc_ok) begin
                     cmd.op   = DP_FILL_ALLOC;
                     state_in = sts.leaf ? S_DONE : S_READ;
                  end else begin
                     state_in = S_UNDO;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         // roll back entries written by a fill that ran out of frames
         S_UNDO: begin
            if (sts.undo_empty) begin
               cmd.op   = DP_FAIL;
               state_in = S_DONE;
            end else begin
               cmd.op = DP_UNDO;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hdl/four_level_page_table_walker.sv -----
`default_nettype none

// Four-level page table walker. Each check, unmap or fill request walks the
// tables from the root frame (csr_data, which the user is to write only while
// idle; the block does not enforce this), nine address bits per level, in a
// single-port table memory with registered read; each level has a read step
// and then an evaluate/write-back step, between accept and result. When the
// allocator runs dry, a fill rolls back the entries it wrote before its result.
// One request is worked on at a time; the result register lets the next
// request be accepted while a result waits. After reset a clearing pass
// zeroes all FRAME_COUNT*512 entries of the table store (32768 at the
// default), while req_tready stays low.

module four_level_page_table_walker #(
   parameter int FRAME_COUNT = fptw_pkg::FRAME_COUNT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: tdata = vaddr[47:0], writable[48], zero fill; tuser = opcode
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [fptw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [fptw_pkg::OPCODE_W-1:0]   req_tuser,
   // response: tdata = mapped, freed, freed_frame[5:0], data_frame[5:0],
   // frames_taken[2:0], out_of_frames, zero fill
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [fptw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // root frame register
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fptw_pkg::ROOT_W-1:0]     csr_data
);
   import fptw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   fptw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fptw_dp #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- verif/walk_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, response and root frame channels of the walker. Keeps its
// own copy of the page tables, the frame allocator and the root frame. Predicts
// the response to every accepted request word and compares each response word
// with the oldest prediction.
module walk_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [fptw_pkg::REQ_DATA_W-1:0] req_tdata,  // vaddr[47:0], writable,
                                                            // zero fill
   input  wire logic [fptw_pkg::OPCODE_W-1:0]   req_tuser,  // opcode
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [fptw_pkg::RSP_DATA_W-1:0] rsp_tdata,  // mapped, freed, freed_frame,
                                                            // data_frame, frames_taken,
                                                            // out_of_frames, zero fill
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [fptw_pkg::ROOT_W-1:0]     csr_data,
   output int                                   mismatches,
   output int                                   outstanding
);
   import fptw_pkg::*;

   localparam int STORE_DEPTH = FRAME_COUNT_DEF * ENTRIES_PER_TABLE;
   localparam int FRAME_W     = $clog2(FRAME_COUNT_DEF);
   localparam int ENTRY_W     = OFFSET_W + FRAME_W;

   // response fields, lowest bit last in the list
   typedef struct packed {
      logic                   out_of_frames;
      logic [TAKEN_W-1:0]     frames_taken;
      logic [FRAME_OUT_W-1:0] data_frame;
      logic [FRAME_OUT_W-1:0] freed_frame;
      logic                   freed;
      logic                   mapped;
   } walk_result_type;

   // mirror of the table store, allocator and root register
   logic [ENTRY_W-1:0]   pt_mem [STORE_DEPTH];
   logic [FRAME_W:0]     alloc_ptr;
   logic [ROOT_W-1:0]    cur_root;

   walk_result_type walk_results [$];
   walk_result_type want, got;
   int              bad_words = 0;

   // Walks the four levels for one request and applies its effect on the tables.
   function automatic walk_result_type page_walk(op_type op, logic [VADDR_W-1:0] va,
                                                 logic wr);
      walk_result_type      r;
      logic [FLAG_W-1:0]    acc;
      logic [FRAME_W-1:0]   frame;
      logic [FRAME_W-1:0]   nf;
      logic [FRAME_W+IDX_W-1:0] pos;
      logic [ENTRY_W-1:0]   ent;
      logic [FRAME_W+IDX_W-1:0] undo_pos [LEVELS];
      logic [ENTRY_W-1:0]   undo_val [LEVELS];
      logic [FRAME_W:0]     saved_ptr;
      logic [TAKEN_W-1:0]   taken;
      logic [FRAME_W-1:0]   data;
      logic                 going;
      int                   n;
      r      = '0;
      acc    = {1'b1, wr, 1'b1};   // user, writable, present
      frame  = cur_root;
      going  = 1'b1;
      n      = 0;
      taken  = '0;
      data   = '0;
      saved_ptr = alloc_ptr;
      case (op)
         OP_CHECK, OP_UNMAP: begin
            for (int l = 0; l < LEVELS && going; l++) begin
               pos = {frame, va[OFFSET_W + IDX_W*(LEVELS-1-l) +: IDX_W]};
               ent = pt_mem[pos];
               if (!ent[0]) begin
                  going = 1'b0;
               end else if (l == LEVELS-1) begin
                  if (op == OP_CHECK) begin
                     r.mapped = 1'b1;
                  end else begin
                     r.freed       = 1'b1;
                     r.freed_frame = ent[ENTRY_W-1:OFFSET_W];
                     pt_mem[pos]   = '0;
                  end
               end else begin
                  frame = ent[ENTRY_W-1:OFFSET_W];
               end
            end
         end
         OP_FILL: begin
            for (int l = 0; l < LEVELS && going; l++) begin
               pos = {frame, va[OFFSET_W + IDX_W*(LEVELS-1-l) +: IDX_W]};
               ent = pt_mem[pos];
               undo_pos[n] = pos;
               undo_val[n] = ent;
               if (l < LEVELS-1 && ent[0]) begin
                  // present upper entry: keep frame, merge access bits
                  n++;
                  frame       = ent[ENTRY_W-1:OFFSET_W];
                  pt_mem[pos] = ent | ENTRY_W'(acc);
               end else if (alloc_ptr >= FRAME_COUNT_DEF) begin
                  going = 1'b0;
               end else begin
                  // fresh table frame, or the new data frame at the leaf
                  nf          = alloc_ptr[FRAME_W-1:0];
                  alloc_ptr   = alloc_ptr + (FRAME_W+1)'(1);
                  taken       = taken + TAKEN_W'(1);
                  n++;
                  pt_mem[pos] = {nf, {(OFFSET_W-FLAG_W){1'b0}}, acc};
                  frame       = nf;
                  if (l == LEVELS-1)
                     data = nf;
               end
            end
            if (!going) begin
               // allocator ran dry: roll back in reverse order
               while (n > 0) begin
                  n--;
                  pt_mem[undo_pos[n]] = undo_val[n];
               end
               alloc_ptr       = saved_ptr;
               r.out_of_frames = 1'b1;
            end else begin
               r.data_frame   = data;
               r.frames_taken = taken;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++)
            pt_mem[i] = '0;
         alloc_ptr = 1;
         cur_root  = '0;
         walk_results.delete();
      end else begin
         if (csr_valid && csr_ready)
            cur_root = csr_data;

         // response first: it belongs to an earlier request than one accepted now
         if (rsp_tvalid && rsp_tready) begin
            if (walk_results.size() == 0) begin
               bad_words++;
               if (bad_words <= 10)
                  $display("%t: response word %h with no request waiting", $realtime,
                           rsp_tdata);
            end else begin
               want = walk_results.pop_front();
               got  = walk_result_type'(rsp_tdata[RSP_USED_W-1:0]);
               if (got !== want || rsp_tdata[RSP_DATA_W-1:RSP_USED_W] !== '0) begin
                  bad_words++;
                  if (bad_words <= 10) begin
                     $display("%t: response mismatch", $realtime);
                     $display("   exp mapped %0d freed %0d freed_frame %0d data_frame %0d taken %0d out_of_frames %0d pad 0",
                              want.mapped, want.freed, want.freed_frame,
                              want.data_frame, want.frames_taken, want.out_of_frames);
                     $display("   got mapped %0d freed %0d freed_frame %0d data_frame %0d taken %0d out_of_frames %0d pad %h",
                              got.mapped, got.freed, got.freed_frame,
                              got.data_frame, got.frames_taken, got.out_of_frames,
                              rsp_tdata[RSP_DATA_W-1:RSP_USED_W]);
                  end
               end
            end
         end

         if (req_tvalid && req_tready)
            walk_results.push_back(page_walk(op_type'(req_tuser),
                                             req_tdata[VADDR_W-1:0],
                                             req_tdata[REQ_WRITABLE_BIT]));
      end
      mismatches  <= bad_words;
      outstanding <= walk_results.size();
   end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import fptw_pkg::*;

   localparam int PHASE_ITEMS = 80;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OPCODE_W-1:0]   req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [ROOT_W-1:0]     csr_data;

   int          mismatches;
   int          outstanding;
   logic        quiet = 1'b0;        // no idling on either side
   int unsigned stall_left = 0;

   logic [VADDR_W-1:0] filled_pages [$];

   four_level_page_table_walker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   walk_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random stall bursts of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one request word, with an optional idle burst in front
   task automatic send_req(op_type op, logic [VADDR_W-1:0] va, logic wr);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-VADDR_W-1){1'b0}}, wr, va};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      if (op == OP_FILL) begin
         filled_pages.push_back(va);
         if (filled_pages.size() > 32)
            void'(filled_pages.pop_front());
      end
   endtask

   // hold off requests until every predicted response has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_root(logic [ROOT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic [VADDR_W-1:0]  va;
      logic [IDX_W-1:0]    hot [4];
      logic [ROOT_W-1:0]   roots [5];
      op_type              op;
      int                  pick;

      hot = '{9'd0, 9'd1, 9'd256, 9'd511};
      roots[0] = 6'd63;
      roots[1] = 6'd0;
      roots[2] = 6'd1;
      roots[3] = ROOT_W'($urandom_range(0, 63));
      roots[4] = 6'd0;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_NOP;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tables, first mapping, upper-level reuse, leaf overwrite
      write_root(6'd0);
      send_req(OP_CHECK, 48'h0, 1'b0);
      send_req(OP_UNMAP, 48'h0, 1'b0);
      send_req(OP_FILL,  48'h0, 1'b0);
      send_req(OP_CHECK, 48'h0, 1'b0);
      send_req(OP_FILL,  48'h0, 1'b1);               // leaf present, overwritten
      send_req(OP_FILL,  48'hFFFF_FFFF_FFFF, 1'b1);
      send_req(OP_CHECK, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_req(OP_UNMAP, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_req(OP_CHECK, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_req(OP_UNMAP, 48'hFFFF_FFFF_FFFF, 1'b1);  // already gone
      send_req(OP_NOP,   48'hA5A5_5A5A_F0F0, 1'b1);
      send_req(OP_NOP,   48'h0, 1'b0);
      send_req(OP_FILL,  48'h0000_0000_1000, 1'b0);  // new leaf only
      send_req(OP_FILL,  48'h0000_0020_0000, 1'b1);  // new leaf table
      send_req(OP_FILL,  48'h0000_4000_0000, 1'b0);  // two new levels
      send_req(OP_CHECK, 48'h0000_0000_0FFF, 1'b0);  // offset bits ignored
      send_req(OP_UNMAP, 48'h0000_0000_0ABC, 1'b0);
      send_req(OP_CHECK, 48'h8000_0000_0000, 1'b0);
      drain_results();

      // random phases, each under a root frame taken from the roots list
      for (int ph = 0; ph < 5; ph++) begin
         write_root(roots[ph]);
         quiet = (ph == 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
               op = OP_FILL;
            else if (pick < 60)
               op = OP_CHECK;
            else if (pick < 93)
               op = OP_UNMAP;
            else
               op = OP_NOP;

            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               va = VADDR_W'({$urandom, $urandom});
            end else if (pick < 60 && filled_pages.size() != 0) begin
               va = filled_pages[$urandom_range(0, filled_pages.size() - 1)];
               va[OFFSET_W-1:0] = OFFSET_W'($urandom);
            end else begin
               // clustered indices so fills share upper tables
               va[OFFSET_W-1:0] = OFFSET_W'($urandom);
               for (int l = 0; l < LEVELS; l++)
                  va[OFFSET_W + IDX_W*l +: IDX_W] = ($urandom_range(0, 7) == 0) ?
                     IDX_W'($urandom) : hot[$urandom_range(0, 3)];
            end

            send_req(op, va, 1'($urandom_range(0, 1)));
            if (!quiet && $urandom_range(0, 49) == 0)
               drain_results();
         end
         drain_results();
      end

      // trailing window for stray responses
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // timeout
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
